### hdl/bpfa_pkg.sv
// Shared constants for the bitmap page frame allocator.
// Field widths, action and status codes, parameter defaults. No dependencies.
`default_nettype none
package bpfa_pkg;

    localparam int TP_W       = 17;
    localparam int ACTION_W   = 2;
    localparam int ADDR_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int PADDR_W    = 28;
    localparam int WORD_BITS  = 64;
    localparam int BIT_IDX_W  = 6;
    localparam int CMP_W      = ADDR_W + 1;

    localparam int PAGE_BYTES_DEF = 4096;
    localparam int MAX_PAGES_DEF  = 65536;

    localparam logic [ACTION_W-1:0] ACT_ALLOC   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FREE    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RESERVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;

endpackage
`default_nettype wire

### hdl/bpfa_ffz.sv
// Find-first-zero unit over one 64-bit bitmap word, used by the alloc scan.
// Depends on bpfa_pkg.
`default_nettype none
module bpfa_ffz
    import bpfa_pkg::*;
(
    input  wire logic [WORD_BITS-1:0] i_word,
    output logic                      o_found,
    output logic [BIT_IDX_W-1:0]      o_index
);

    always_comb begin
        o_found = 1'b0;
        o_index = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!i_word[i]) begin
                o_found = 1'b1;
                o_index = BIT_IDX_W'(i);
            end
        end
    end

endmodule
`default_nettype wire

### hdl/bpfa_bitmap.sv
// Page bitmap store: one write port, one read port with registered read data.
// Depends on bpfa_pkg.
`default_nettype none
module bpfa_bitmap
    import bpfa_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [AW-1:0]        i_waddr,
    input  wire logic [WORD_BITS-1:0] i_wdata,
    input  wire logic                 i_re,
    input  wire logic [AW-1:0]        i_raddr,
    output logic      [WORD_BITS-1:0] o_rdata
);

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [WORD_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### hdl/bitmap_page_frame_allocator_core.sv
// First-fit bitmap page frame allocator: sequencer, bitmap store and scan unit.
// Depends on bpfa_pkg, bpfa_bitmap and bpfa_ffz.
//
// One bit per page (1 = allocated). After reset the block sweeps the bitmap to
// all-allocated, one word per cycle, and takes no request meanwhile; page
// count writes are taken at any time. One request is in flight at a time.
// Alloc scans the bitmap one 64-bit word per cycle through the single read
// port and find-first-zero unit, stopping at the first free page below the
// limit. Free and reserve are a read-modify-write of one word. An out-of-range
// page or an alloc with a zero limit goes straight to the result state.
// PAGE_BYTES must be a power of two.
`default_nettype none
module bitmap_page_frame_allocator_core
    import bpfa_pkg::*;
#(
    parameter int PAGE_BYTES = PAGE_BYTES_DEF,
    parameter int MAX_PAGES  = MAX_PAGES_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [ACTION_W-1:0] i_action,
    input  wire logic [ADDR_W-1:0]   i_address,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic      [STATUS_W-1:0] o_status,
    output logic      [PADDR_W-1:0]  o_page_address,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [TP_W-1:0]     i_cfg_num_pages
);

    localparam int WORD_COUNT = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int CNT_W      = $clog2(WORD_COUNT + 1);
    localparam int PAGE_W     = WIDX_W + BIT_IDX_W;
    localparam int OFFSET_W   = $clog2(PAGE_BYTES);
    localparam int LIM_NAT_W  = $clog2(MAX_PAGES + 1);
    localparam int LIM_W      = (LIM_NAT_W > TP_W) ? LIM_NAT_W : TP_W;
    localparam int FULL_W     = PADDR_W + PAGE_W + OFFSET_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_RMW_RD,
        S_RMW_WR,
        S_RESULT
    } t_state;

    t_state                r_state, n_state;
    logic [TP_W-1:0]       r_num_pages, n_num_pages;
    logic [CNT_W-1:0]      r_idx, n_idx;
    logic [CNT_W-1:0]      r_nwords, n_nwords;
    logic [BIT_IDX_W-1:0]  r_tail, n_tail;
    logic                  r_chk_vld, n_chk_vld;
    logic [WIDX_W-1:0]     r_chk_word, n_chk_word;
    logic [WIDX_W-1:0]     r_word, n_word;
    logic [BIT_IDX_W-1:0]  r_bit, n_bit;
    logic                  r_set, n_set;
    logic [STATUS_W-1:0]   r_res_status, n_res_status;
    logic [PADDR_W-1:0]    r_res_addr, n_res_addr;
    logic                  r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]   r_status, n_status;
    logic [PADDR_W-1:0]    r_page_addr, n_page_addr;

    logic [LIM_W-1:0]      w_limit;
    logic [LIM_W:0]        w_nwords_full;
    logic [CMP_W-1:0]      w_in_page;
    logic                  w_in_range;
    logic                  w_accept;

    logic                  w_re;
    logic [WIDX_W-1:0]     w_raddr;
    logic                  w_we;
    logic [WIDX_W-1:0]     w_waddr;
    logic [WORD_BITS-1:0]  w_wdata;
    logic [WORD_BITS-1:0]  w_rdata;

    logic                  w_last;
    logic [WORD_BITS-1:0]  w_masked;
    logic                  w_found;
    logic [BIT_IDX_W-1:0]  w_found_bit;
    logic [PAGE_W-1:0]     w_found_page;
    logic [FULL_W-1:0]     w_found_full;
    logic [WORD_BITS-1:0]  w_bit_onehot;

    bpfa_bitmap #(
        .DEPTH (WORD_COUNT),
        .AW    (WIDX_W)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    bpfa_ffz u_ffz (
        .i_word  (w_masked),
        .o_found (w_found),
        .o_index (w_found_bit)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;

    assign w_limit = (LIM_W'(r_num_pages) > LIM_W'(MAX_PAGES)) ?
                     LIM_W'(MAX_PAGES) : LIM_W'(r_num_pages);
    assign w_nwords_full = ((LIM_W + 1)'(w_limit) + (LIM_W + 1)'(WORD_BITS - 1))
                           >> BIT_IDX_W;
    assign w_in_page  = CMP_W'(i_address >> OFFSET_W);
    assign w_in_range = w_in_page < CMP_W'(w_limit);

    // scan word check: pages at or above the limit in the last word read as taken
    assign w_last   = (CNT_W'(r_chk_word) == (r_nwords - CNT_W'(1)));
    assign w_masked = (w_last && (r_tail != '0)) ?
                      (w_rdata | ({WORD_BITS{1'b1}} << r_tail)) : w_rdata;
    assign w_found_page = {r_chk_word, w_found_bit};
    assign w_found_full = FULL_W'({w_found_page, {OFFSET_W{1'b0}}});

    always_comb begin
        w_bit_onehot = '0;
        unique case (r_state)
            S_SCAN:  w_bit_onehot[w_found_bit] = 1'b1;
            default: w_bit_onehot[r_bit] = 1'b1;
        endcase
    end

    always_comb begin
        w_re    = 1'b0;
        w_raddr = r_idx[WIDX_W-1:0];
        w_we    = 1'b0;
        w_waddr = r_idx[WIDX_W-1:0];
        w_wdata = {WORD_BITS{1'b1}};

        n_state       = r_state;
        n_num_pages   = r_num_pages;
        n_idx         = r_idx;
        n_nwords      = r_nwords;
        n_tail        = r_tail;
        n_chk_vld     = 1'b0;
        n_chk_word    = r_chk_word;
        n_word        = r_word;
        n_bit         = r_bit;
        n_set         = r_set;
        n_res_status  = r_res_status;
        n_res_addr    = r_res_addr;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_status      = r_status;
        n_page_addr   = r_page_addr;

        if (i_cfg_valid) begin
            n_num_pages = i_cfg_num_pages;
        end

        unique case (r_state)
            S_CLEAR: begin
                w_we  = 1'b1;
                n_idx = r_idx + CNT_W'(1);
                if (r_idx == CNT_W'(WORD_COUNT - 1)) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_res_status = ST_OK;
                    n_res_addr   = '0;
                    n_word       = w_in_page[PAGE_W-1:BIT_IDX_W];
                    n_bit        = w_in_page[BIT_IDX_W-1:0];
                    n_set        = (i_action == ACT_RESERVE);
                    n_state      = S_RESULT;
                    unique case (i_action)
                        ACT_ALLOC: begin
                            if (w_nwords_full == '0) begin
                                n_res_status = ST_NONE_FREE;
                            end else begin
                                n_idx    = '0;
                                n_nwords = CNT_W'(w_nwords_full);
                                n_tail   = w_limit[BIT_IDX_W-1:0];
                                n_state  = S_SCAN;
                            end
                        end
                        ACT_FREE, ACT_RESERVE: begin
                            if (w_in_range) begin
                                n_state = S_RMW_RD;
                            end else begin
                                n_res_status = ST_RANGE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                w_re       = (r_idx < r_nwords);
                w_raddr    = r_idx[WIDX_W-1:0];
                n_chk_vld  = w_re;
                n_chk_word = r_idx[WIDX_W-1:0];
                if (w_re) begin
                    n_idx = r_idx + CNT_W'(1);
                end
                if (r_chk_vld) begin
                    if (w_found) begin
                        w_we         = 1'b1;
                        w_waddr      = r_chk_word;
                        w_wdata      = w_rdata | w_bit_onehot;
                        n_res_status = ST_OK;
                        n_res_addr   = w_found_full[PADDR_W-1:0];
                        n_chk_vld    = 1'b0;
                        n_state      = S_RESULT;
                    end else if (w_last) begin
                        n_res_status = ST_NONE_FREE;
                        n_chk_vld    = 1'b0;
                        n_state      = S_RESULT;
                    end
                end
            end
            S_RMW_RD: begin
                w_re    = 1'b1;
                w_raddr = r_word;
                n_state = S_RMW_WR;
            end
            S_RMW_WR: begin
                w_we    = 1'b1;
                w_waddr = r_word;
                w_wdata = r_set ? (w_rdata | w_bit_onehot) : (w_rdata & ~w_bit_onehot);
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (!n_out_valid) begin
                    n_out_valid = 1'b1;
                    n_status    = r_res_status;
                    n_page_addr = r_res_addr;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_nwords     <= n_nwords;
        r_tail       <= n_tail;
        r_chk_word   <= n_chk_word;
        r_word       <= n_word;
        r_bit        <= n_bit;
        r_set        <= n_set;
        r_res_status <= n_res_status;
        r_res_addr   <= n_res_addr;
        r_status     <= n_status;
        r_page_addr  <= n_page_addr;
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_num_pages <= '0;
            r_idx       <= '0;
            r_chk_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_num_pages <= n_num_pages;
            r_idx       <= n_idx;
            r_chk_vld   <= n_chk_vld;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_page_address = r_page_addr;

endmodule
`default_nettype wire
